[rtl/vp8rtp_pkg.sv]
// Shared types for the VP8 RTP payload descriptor parser.
// Holds the byte and result transaction structs; no dependencies.
package vp8rtp_pkg;

	// One payload byte and its end-of-packet mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_t;

	// Parsed descriptor and payload header, one per packet
	typedef struct packed {
		logic        status;
		logic [2:0]  descriptor_length;
		logic        nonref_frame;
		logic        start_partition;
		logic [3:0]  partition_index;
		logic [4:0]  present_flags;
		logic [14:0] picture_id;
		logic [7:0]  tl0_pic_index;
		logic [7:0]  temporal_key_byte;
		logic        payload_header_valid;
		logic [4:0]  frame_info;
		logic [18:0] part0_size;
	} result_t;

	// Status codes
	localparam logic STATUS_COMPLETE  = 1'b0;
	localparam logic STATUS_TRUNCATED = 1'b1;

endpackage

[rtl/vp8_rtp_descriptor_parser.sv]
// VP8 RTP payload descriptor parser, top level.
// Depends on vp8rtp_pkg for the byte and result structs.

// Takes one payload byte per cycle on the byte channel and gives one result per
// packet on the result channel: on the byte that completes the descriptor (and
// the 3-byte VP8 payload header when S=1 and PID=0), or with truncated status on
// the last byte if the packet ends first. Bytes after a complete header are
// dropped until the last byte. Each byte is held in the input register, and its
// result, if any, is then registered in the result register. The byte channel
// sustains one byte per cycle; it stalls only while a result waits in the result
// register and the input register also holds a byte.
module vp8_rtp_descriptor_parser
	import vp8rtp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    byte_valid,
	output logic    byte_stall,
	input  byte_t   byte_data,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result_data
);

	typedef enum logic [3:0] {
		PH_FIRST, PH_EXT, PH_PIC0, PH_PIC1, PH_TL0, PH_TK,
		PH_HDR0, PH_HDR1, PH_HDR2, PH_DONE
	} phase_t;

	// First phase at or after start that the flags call for
	function automatic phase_t seek_phase(logic [3:0] start, logic [6:0] df,
		logic [4:0] ef);
		phase_t p;
		logic   need;
		p = PH_DONE;
		for (int i = 8; i >= 1; i--) begin
			case (phase_t'(4'(i)))
				PH_EXT:  need = df[6];
				PH_PIC0: need = ef[4];
				PH_PIC1: need = ef[4] & ef[0];
				PH_TL0:  need = ef[3];
				PH_TK:   need = ef[2] | ef[1];
				PH_HDR0, PH_HDR1, PH_HDR2: need = df[4] & (df[3:0] == 4'd0);
				default: need = 1'b1;
			endcase
			if (4'(i) >= start && need)
				p = phase_t'(4'(i));
		end
		return p;
	endfunction

	// Input register
	logic  valid_s1;
	byte_t byte_s1;

	// Packet state
	phase_t      phase_q;
	logic [6:0]  dflags_q;  // bit6 X, bit5 N, bit4 S, 3:0 PID
	logic [4:0]  eflags_q;  // I, L, T, K, long picture id
	logic [14:0] pic_q;
	logic [7:0]  tl0_q;
	logic [7:0]  tk_q;
	logic [4:0]  finfo_q;
	logic [18:0] psize_q;
	logic [2:0]  count_q;

	phase_t      phase_n;
	logic [6:0]  dflags_n;
	logic [4:0]  eflags_n;
	logic [14:0] pic_n;
	logic [7:0]  tl0_n;
	logic [7:0]  tk_n;
	logic [4:0]  finfo_n;
	logic [18:0] psize_n;
	logic [2:0]  count_n;
	phase_t      seek;
	logic        emit;
	result_t     res;

	logic advance;
	logic fire;

	// Input register moves on when the result register can take its outcome
	assign advance    = !result_valid || !result_stall;
	assign fire       = valid_s1 && advance;
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall)
			byte_s1 <= byte_data;
	end

	// Field extraction for the byte in the input register
	always_comb begin
		phase_n  = phase_q;
		dflags_n = dflags_q;
		eflags_n = eflags_q;
		pic_n    = pic_q;
		tl0_n    = tl0_q;
		tk_n     = tk_q;
		finfo_n  = finfo_q;
		psize_n  = psize_q;
		count_n  = count_q;
		emit     = 1'b0;
		res      = '0;

		case (phase_q)
			PH_FIRST: begin
				dflags_n = {byte_s1.data_byte[7], byte_s1.data_byte[5:0]};
				count_n  = 3'd1;
			end
			PH_EXT: begin
				eflags_n = {byte_s1.data_byte[7:4], 1'b0};
				count_n  = count_q + 3'd1;
			end
			PH_PIC0: begin
				eflags_n[0] = byte_s1.data_byte[7];
				pic_n       = {8'd0, byte_s1.data_byte[6:0]};
				count_n     = count_q + 3'd1;
			end
			PH_PIC1: begin
				pic_n   = {pic_q[6:0], byte_s1.data_byte};
				count_n = count_q + 3'd1;
			end
			PH_TL0: begin
				tl0_n   = byte_s1.data_byte;
				count_n = count_q + 3'd1;
			end
			PH_TK: begin
				tk_n    = byte_s1.data_byte;
				count_n = count_q + 3'd1;
			end
			PH_HDR0: begin
				finfo_n = byte_s1.data_byte[4:0];
				psize_n = {16'd0, byte_s1.data_byte[7:5]};
			end
			PH_HDR1: begin
				psize_n = psize_q + {8'd0, byte_s1.data_byte, 3'd0};
			end
			PH_HDR2: begin
				psize_n = psize_q + {byte_s1.data_byte, 11'd0};
			end
			default: begin
			end
		endcase

		seek = seek_phase(4'(phase_q) + 4'd1, dflags_n, eflags_n);

		// Result fields
		res.descriptor_length = count_n;
		if (seek == PH_DONE) begin
			res.status               = STATUS_COMPLETE;
			res.nonref_frame         = dflags_n[5];
			res.start_partition      = dflags_n[4];
			res.partition_index      = dflags_n[3:0];
			res.present_flags        = eflags_n;
			res.picture_id           = pic_n;
			res.tl0_pic_index        = tl0_n;
			res.temporal_key_byte    = tk_n;
			res.payload_header_valid = dflags_n[4] & (dflags_n[3:0] == 4'd0);
			res.frame_info           = finfo_n;
			res.part0_size           = psize_n;
		end else begin
			res.status = STATUS_TRUNCATED;
		end

		// Phase advance and packet restart
		if (phase_q != PH_DONE) begin
			emit    = (seek == PH_DONE) || byte_s1.last_byte;
			phase_n = seek;
		end
		if (byte_s1.last_byte) begin
			phase_n  = PH_FIRST;
			dflags_n = '0;
			eflags_n = '0;
			pic_n    = '0;
			tl0_n    = '0;
			tk_n     = '0;
			finfo_n  = '0;
			psize_n  = '0;
			count_n  = '0;
		end
	end

	// Packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			dflags_q <= '0;
			eflags_q <= '0;
			pic_q    <= '0;
			tl0_q    <= '0;
			tk_q     <= '0;
			finfo_q  <= '0;
			psize_q  <= '0;
			count_q  <= '0;
		end else if (fire) begin
			phase_q  <= phase_n;
			dflags_q <= dflags_n;
			eflags_q <= eflags_n;
			pic_q    <= pic_n;
			tl0_q    <= tl0_n;
			tk_q     <= tk_n;
			finfo_q  <= finfo_n;
			psize_q  <= psize_n;
			count_q  <= count_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit)
			result_data <= res;
	end

endmodule

[rtl/vp8rtp_checker.sv]
// Port-level checks for the VP8 RTP descriptor parser, bound to the top level.
// Depends on vp8rtp_pkg and on vp8_rtp_descriptor_parser.
module vp8rtp_checker
	import vp8rtp_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result_data
);

	// A stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// Truncated results carry only the length
	a_trunc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.status == STATUS_TRUNCATED |->
			result_data.picture_id == 15'd0 && result_data.present_flags == 5'd0 &&
			result_data.payload_header_valid == 1'b0 &&
			result_data.part0_size == 19'd0)
		else $error("truncated result has fields set");

	// Descriptor length stays within one to six bytes
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_data.descriptor_length >= 3'd1 &&
			result_data.descriptor_length <= 3'd6)
		else $error("descriptor length out of range");

	// Payload header only at partition start with index zero
	a_hdr_start: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.payload_header_valid |->
			result_data.start_partition && result_data.partition_index == 4'd0)
		else $error("payload header without partition start");

	// No payload header means no frame fields
	a_hdr_absent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.payload_header_valid |->
			result_data.frame_info == 5'd0 && result_data.part0_size == 19'd0)
		else $error("frame fields set without payload header");

endmodule

bind vp8_rtp_descriptor_parser vp8rtp_checker u_vp8rtp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_data  (result_data)
);

[sim/vp8_rtp_descriptor_parser_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for vp8_rtp_descriptor_parser: streams VP8 RTP payloads
// through the byte channel and checks every result against a built-in parser.
// Depends on vp8rtp_pkg and the parser RTL.
module vp8_rtp_descriptor_parser_test
	import vp8rtp_pkg::*;
();

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    byte_valid = 1'b0;
	logic    byte_stall;
	byte_t   byte_data = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result_data;

	vp8_rtp_descriptor_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_data    (byte_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	always #1 clk = ~clk;

	// Parser position within a packet
	typedef enum logic [3:0] {
		P_FIRST, P_EXT, P_PIC_HI, P_PIC_LO, P_TL0, P_TEMPKEY,
		P_HDR0, P_HDR1, P_HDR2, P_DONE
	} parse_phase_t;

	byte_t   bytes_to_send[$];
	result_t results_due[$];
	int      bytes_taken = 0;
	int      errors = 0;

	// Predicted parser state
	parse_phase_t phase;
	logic         desc_x, desc_n, desc_s;
	logic [3:0]   desc_pid;
	logic [4:0]   ext_flags;
	logic [14:0]  pic_id;
	logic [7:0]   tl0_idx, temp_key;
	logic [4:0]   finfo;
	logic [18:0]  part_size;
	logic [2:0]   desc_count;

	task automatic restart_packet();
		phase = P_FIRST;
		{desc_x, desc_n, desc_s, desc_pid} = '0;
		ext_flags = '0;
		pic_id = '0;
		tl0_idx = '0;
		temp_key = '0;
		finfo = '0;
		part_size = '0;
		desc_count = '0;
	endtask

	function automatic logic hdr_wanted();
		return desc_s && desc_pid == 4'd0;
	endfunction

	function automatic logic step_required(parse_phase_t p);
		case (p)
			P_EXT:                  return desc_x;
			P_PIC_HI:               return ext_flags[4];
			P_PIC_LO:               return ext_flags[4] && ext_flags[0];
			P_TL0:                  return ext_flags[3];
			P_TEMPKEY:              return ext_flags[2:1] != 2'b00;
			P_HDR0, P_HDR1, P_HDR2: return hdr_wanted();
			default:                return 1'b1;
		endcase
	endfunction

	// Advance the predicted parser by one byte; has_res marks a result
	task automatic advance_parser(input byte_t b, output logic has_res, output result_t r);
		logic [7:0]   v;
		parse_phase_t nxt;
		v = b.data_byte;
		has_res = 1'b0;
		r = '0;
		if (phase == P_DONE) begin
			if (b.last_byte)
				restart_packet();
			return;
		end
		case (phase)
			P_FIRST: begin
				desc_x = v[7];
				desc_n = v[5];
				desc_s = v[4];
				desc_pid = v[3:0];
				desc_count = 3'd1;
			end
			P_EXT: begin
				ext_flags = {v[7:4], 1'b0};
				desc_count++;
			end
			P_PIC_HI: begin
				ext_flags[0] = v[7];
				pic_id = {8'd0, v[6:0]};
				desc_count++;
			end
			P_PIC_LO: begin
				pic_id = {pic_id[6:0], v};
				desc_count++;
			end
			P_TL0: begin
				tl0_idx = v;
				desc_count++;
			end
			P_TEMPKEY: begin
				temp_key = v;
				desc_count++;
			end
			P_HDR0: begin
				finfo = v[4:0];
				part_size = {16'd0, v[7:5]};
			end
			P_HDR1:  part_size += {8'd0, v, 3'd0};
			default: part_size += {v, 11'd0};
		endcase

		nxt = parse_phase_t'(phase + 4'd1);
		while (nxt < P_DONE && !step_required(nxt))
			nxt = parse_phase_t'(nxt + 4'd1);

		if (nxt == P_DONE) begin
			has_res = 1'b1;
			r.status = STATUS_COMPLETE;
			r.descriptor_length = desc_count;
			r.nonref_frame = desc_n;
			r.start_partition = desc_s;
			r.partition_index = desc_pid;
			r.present_flags = ext_flags;
			r.picture_id = pic_id;
			r.tl0_pic_index = tl0_idx;
			r.temporal_key_byte = temp_key;
			r.payload_header_valid = hdr_wanted();
			r.frame_info = finfo;
			r.part0_size = part_size;
			if (b.last_byte)
				restart_packet();
			else
				phase = P_DONE;
		end else if (b.last_byte) begin
			has_res = 1'b1;
			r.status = STATUS_TRUNCATED;
			r.descriptor_length = desc_count;
			restart_packet();
		end else begin
			phase = nxt;
		end
	endtask

	// Queue one packet, last_byte set on its final byte
	task automatic queue_packet(input logic [7:0] pkt[$]);
		byte_t b;
		for (int i = 0; i < pkt.size(); i++) begin
			b.data_byte = pkt[i];
			b.last_byte = (i == pkt.size() - 1);
			bytes_to_send.push_back(b);
		end
	endtask

	// Random well-formed packet, sometimes cut short
	task automatic queue_random_packet();
		logic [7:0] pkt[$];
		logic [7:0] lead, ext, pic_hi;
		int         keep;
		lead = 8'($urandom);
		if ($urandom_range(0, 99) < 40)
			lead[4:0] = 5'b10000;
		pkt.push_back(lead);
		if (lead[7]) begin
			ext = 8'($urandom);
			pkt.push_back(ext);
			if (ext[7]) begin
				pic_hi = 8'($urandom);
				pkt.push_back(pic_hi);
				if (pic_hi[7])
					pkt.push_back(8'($urandom));
			end
			if (ext[6])
				pkt.push_back(8'($urandom));
			if (ext[5] || ext[4])
				pkt.push_back(8'($urandom));
		end
		if (lead[4] && lead[3:0] == 4'd0)
			repeat (3) pkt.push_back(8'($urandom));
		repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
		if ($urandom_range(0, 99) < 15) begin
			keep = $urandom_range(1, pkt.size());
			while (pkt.size() > keep)
				void'(pkt.pop_back());
		end
		queue_packet(pkt);
	endtask

	// Free-form noise packet
	task automatic queue_noise_packet();
		logic [7:0] pkt[$];
		repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
		queue_packet(pkt);
	endtask

	// No idling on either side through the middle of the run
	function automatic logic take_break();
		if (bytes_taken >= 250 && bytes_taken < 400)
			return 1'b0;
		return $urandom_range(0, 99) < 13;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Byte driver: predicts on each accepted transaction
	always @(posedge clk) begin : byte_driver
		logic    took, has_res;
		result_t r;
		if (arst_n) begin
			took = byte_valid && !byte_stall;
			if (took) begin
				advance_parser(byte_data, has_res, r);
				if (has_res)
					results_due.push_back(r);
				void'(bytes_to_send.pop_front());
				bytes_taken++;
			end
			if (took || !byte_valid) begin
				if (bytes_to_send.size() != 0 && !take_break()) begin
					byte_valid <= 1'b1;
					byte_data <= bytes_to_send[0];
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and stall generator
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (results_due.size() == 0) begin
					$error("result arrived with none expected");
					errors++;
				end else begin
					want = results_due.pop_front();
					check_field("status", want.status, result_data.status);
					check_field("descriptor_length", want.descriptor_length,
						result_data.descriptor_length);
					check_field("nonref_frame", want.nonref_frame,
						result_data.nonref_frame);
					check_field("start_partition", want.start_partition,
						result_data.start_partition);
					check_field("partition_index", want.partition_index,
						result_data.partition_index);
					check_field("present_flags", want.present_flags,
						result_data.present_flags);
					check_field("picture_id", want.picture_id, result_data.picture_id);
					check_field("tl0_pic_index", want.tl0_pic_index,
						result_data.tl0_pic_index);
					check_field("temporal_key_byte", want.temporal_key_byte,
						result_data.temporal_key_byte);
					check_field("payload_header_valid", want.payload_header_valid,
						result_data.payload_header_valid);
					check_field("frame_info", want.frame_info, result_data.frame_info);
					check_field("part0_size", want.part0_size,
						result_data.part0_size);
				end
			end
			result_stall <= take_break();
		end
	end

	// Stimulus, reset and end of run
	initial begin
		restart_packet();

		// One-byte packet, plain descriptor
		queue_packet('{8'h00});
		// Every flag set, long picture ID, no payload header (PID nonzero)
		queue_packet('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
		// Payload header with largest partition size, then trailing bytes
		queue_packet('{8'h10, 8'hFF, 8'hFF, 8'hFF, 8'h55, 8'hAA});
		// Cut off after the short picture ID, before the payload header
		queue_packet('{8'h90, 8'h80, 8'h7F});
		// Header wanted but packet is one byte
		queue_packet('{8'h10});
		// Only K set
		queue_packet('{8'h80, 8'h10, 8'h2A});
		// Short picture ID plus TL0PICIDX
		queue_packet('{8'h80, 8'hC0, 8'h12, 8'h34});

		while (bytes_to_send.size() < 650) begin
			if ($urandom_range(0, 99) < 80)
				queue_random_packet();
			else
				queue_noise_packet();
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_to_send.size() != 0 || results_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog
	initial begin
		#500000;
		$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/vp8rtp_pkg.sv
rtl/vp8_rtp_descriptor_parser.sv
rtl/vp8rtp_checker.sv
sim/vp8_rtp_descriptor_parser_test.sv
